// ===== design/cbpf_pkg.sv =====
// Shared types, constants and helpers for the cubic Bezier path follower.
package cbpf_pkg;

   localparam int COORD_W = 18;
   localparam int DT_W    = 20;
   localparam int GAIN_W  = 16;
   localparam int TIME_W  = 23;
   localparam int PIDX_W  = 7;
   localparam int WORD_W  = 3 * COORD_W;
   localparam int SUMR_W  = 22;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd2560;
   localparam logic [TIME_W-1:0] LOOP_RESET = 23'd2184533;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam logic REG_SPEED_GAIN  = 1'b0;
   localparam logic REG_LOOP_LENGTH = 1'b1;

   localparam logic signed [SUMR_W-1:0] COORD_MAX = 22'sd131071;
   localparam logic signed [SUMR_W-1:0] COORD_MIN = -22'sd131072;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_STEP,
      ST_ADD,
      ST_DIV,
      ST_TPREP,
      ST_W0,
      ST_W1,
      ST_W2,
      ST_W3,
      ST_POS,
      ST_DONE
   } state_type;

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUMR_W-1:0] v);
      logic signed [COORD_W-1:0] r;
      if (v > COORD_MAX) begin
         r = COORD_MAX[COORD_W-1:0];
      end else if (v < COORD_MIN) begin
         r = COORD_MIN[COORD_W-1:0];
      end else begin
         r = v[COORD_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== design/cbpf_req_if.sv =====
// Request channel: point writes and time ticks.
interface cbpf_req_if import cbpf_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic                       op;
   logic [PIDX_W-1:0]          point_index;
   logic signed [COORD_W-1:0]  point_x;
   logic signed [COORD_W-1:0]  point_y;
   logic signed [COORD_W-1:0]  point_z;
   logic [DT_W-1:0]            delta_time;

   modport source (output valid, op, point_index, point_x, point_y, point_z, delta_time,
                   input ready);
   modport sink   (input valid, op, point_index, point_x, point_y, point_z, delta_time,
                   output ready);
endinterface

// ===== design/cbpf_rsp_if.sv =====
// Response channel: path position per tick.
interface cbpf_rsp_if import cbpf_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [COORD_W-1:0]  pos_x;
   logic signed [COORD_W-1:0]  pos_y;
   logic signed [COORD_W-1:0]  pos_z;

   modport source (output valid, pos_x, pos_y, pos_z, input ready);
   modport sink   (input valid, pos_x, pos_y, pos_z, output ready);
endinterface

// ===== design/cubic_bezier_path_follower_core.sv =====
// Cubic Bezier path follower: point table, time wrap, weight and position datapath.
//
//  channel | dir | handshake      | payload
//  --------+-----+----------------+-----------------------------------------------
//  req_bus | in  | valid/ready    | op, point_index, point_x/y/z, delta_time
//  rsp_bus | out | valid/ready    | pos_x, pos_y, pos_z (one beat per tick)
//  csr     | in  | APB psel/pen.. | speed_gain @0x0, loop_length @0x4
//
// A point write lands in the table at its accept edge. A tick runs these steps in
// order from its accept edge to the response: step multiply and add, time wrap in
// a radix-4 remainder unit (cut short at zero loop length), t/u setup and weight
// products on three multiplier lanes, four table reads streamed through the lanes,
// output load. The next request is taken only back in idle, after that load, so
// one item is in flight at a time.
// reset clears control, time and registers; the point table is not cleared.
// A held response stalls the final load; no new request is taken meanwhile.
module cubic_bezier_path_follower_core import cbpf_pkg::*; #(
   parameter int NUM_POINTS = 100
) (
   input  logic               clock,
   input  logic               reset,
   cbpf_req_if.sink           req_bus,
   cbpf_rsp_if.source         rsp_bus,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   localparam int IDX_W     = $clog2(NUM_POINTS);
   localparam int SEG_N     = 1 << (TIME_W - 16);
   localparam int DIV_STEPS = 15;
   localparam int LANES     = 3;
   localparam int PROD_W    = 52;
   localparam int ACC_W     = 54;
   localparam int W_W       = 33;

   // ---------------- configuration registers ----------------
   logic [GAIN_W-1:0] speed_gain_ff;
   logic [TIME_W-1:0] loop_length_ff;
   logic              csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_gain_ff  <= GAIN_RESET;
         loop_length_ff <= LOOP_RESET;
      end else if (csr_wr) begin
         case (paddr[2])
            REG_SPEED_GAIN:  speed_gain_ff  <= pwdata[GAIN_W-1:0];
            REG_LOOP_LENGTH: loop_length_ff <= pwdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_SPEED_GAIN:  prdata = {16'd0, speed_gain_ff};
         REG_LOOP_LENGTH: prdata = {9'd0, loop_length_ff};
         default:         prdata = 32'd0;
      endcase
   end

   // ---------------- segment base table: (3*seg) mod NUM_POINTS ----------------
   logic [IDX_W-1:0] base_tab [SEG_N];

   for (genvar s = 0; s < SEG_N; s++) begin : g_base
      localparam int unsigned BaseVal = (3 * s) % NUM_POINTS;
      assign base_tab[s] = IDX_W'(BaseVal);
   end

   // ---------------- control ----------------
   state_type state_ff, state_in;
   logic      req_take;
   logic      out_busy;
   logic      out_load;

   assign req_take = req_bus.valid & req_bus.ready;
   assign out_busy = rsp_bus.valid & ~rsp_bus.ready;

   // ---------------- point table (single write, single registered read) ----------
   logic [WORD_W-1:0] pts_mem [NUM_POINTS];
   logic [WORD_W-1:0] rdata_ff;
   logic [IDX_W-1:0]  pidx_ff;
   logic              pt_wr;

   assign pt_wr = req_take && (req_bus.op == OP_WRITE)
                  && ({1'b0, req_bus.point_index} < (PIDX_W+1)'(NUM_POINTS));

   always_ff @(posedge clock) begin
      if (pt_wr) begin
         pts_mem[req_bus.point_index[IDX_W-1:0]] <=
            {req_bus.point_x, req_bus.point_y, req_bus.point_z};
      end
      rdata_ff <= pts_mem[pidx_ff];
   end

   // ---------------- datapath registers ----------------
   logic [DT_W-1:0]            delta_ff;
   logic [TIME_W-1:0]          anim_time_ff;
   logic [TIME_W-1:0]          div_len_ff;
   logic [29:0]                num_ff;
   logic [TIME_W-1:0]          rem_ff;
   logic [3:0]                 cnt_ff;
   logic [16:0]                t_ff, u_ff;
   logic [32:0]                ut_ff;
   logic [W_W-1:0]             w_ff [4];
   logic [2:0]                 ki_ff;
   logic signed [PROD_W-1:0]   prod_ff [LANES];
   logic signed [ACC_W-1:0]    acc_ff [LANES];
   logic                       rsp_valid_ff;
   logic signed [COORD_W-1:0]  rsp_x_ff, rsp_y_ff, rsp_z_ff;

   // multiplier lanes
   logic signed [33:0]         mul_a [LANES];
   logic signed [17:0]         mul_b [LANES];
   logic [1:0]                 wsel;
   logic [COORD_W-1:0]         axis_pt [LANES];

   // time wrap: two remainder bits per cycle
   logic [28:0]                num_sum;
   logic [TIME_W:0]            r1, r2;
   logic [TIME_W-1:0]          r1m, r2m;

   // weight triples and t/u setup
   logic [50:0]                x3_ut2, x3_u2t;
   logic [16:0]                t_new;

   // output rounding (floor) before saturation
   logic signed [SUMR_W-1:0]   fl [LANES];

   assign num_sum = 29'(anim_time_ff) + 29'(prod_ff[0][35:8]);

   always_comb begin
      r1  = {rem_ff, num_ff[29]};
      r1m = (r1 >= {1'b0, div_len_ff}) ? TIME_W'(r1 - {1'b0, div_len_ff}) : r1[TIME_W-1:0];
      r2  = {r1m, num_ff[28]};
      r2m = (r2 >= {1'b0, div_len_ff}) ? TIME_W'(r2 - {1'b0, div_len_ff}) : r2[TIME_W-1:0];
   end

   // t is 1.0 on a nonzero whole time, else the fraction
   assign t_new = ((anim_time_ff[15:0] == 16'd0) && (anim_time_ff != '0))
                  ? 17'h10000 : {1'b0, anim_time_ff[15:0]};

   assign x3_ut2 = {1'b0, prod_ff[0][49:0]} + {prod_ff[0][49:0], 1'b0};
   assign x3_u2t = {1'b0, prod_ff[1][49:0]} + {prod_ff[1][49:0], 1'b0};

   assign wsel = 2'(ki_ff - 3'd1);
   assign axis_pt[0] = rdata_ff[WORD_W-1:2*COORD_W];
   assign axis_pt[1] = rdata_ff[2*COORD_W-1:COORD_W];
   assign axis_pt[2] = rdata_ff[COORD_W-1:0];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         mul_a[l] = '0;
         mul_b[l] = '0;
      end
      case (state_ff)
         ST_STEP: begin
            mul_a[0] = 34'(delta_ff);
            mul_b[0] = 18'(speed_gain_ff);
         end
         ST_W0: begin      // u^2, t^2, u*t
            mul_a[0] = 34'(u_ff);  mul_b[0] = 18'(u_ff);
            mul_a[1] = 34'(t_ff);  mul_b[1] = 18'(t_ff);
            mul_a[2] = 34'(u_ff);  mul_b[2] = 18'(t_ff);
         end
         ST_W1: begin      // u^3, u^2*t, t^3
            mul_a[0] = 34'(prod_ff[0][32:0]);  mul_b[0] = 18'(u_ff);
            mul_a[1] = 34'(prod_ff[0][32:0]);  mul_b[1] = 18'(t_ff);
            mul_a[2] = 34'(prod_ff[1][32:0]);  mul_b[2] = 18'(t_ff);
         end
         ST_W2: begin      // u*t^2
            mul_a[0] = 34'(ut_ff);  mul_b[0] = 18'(t_ff);
         end
         ST_POS: begin
            if ((ki_ff >= 3'd1) && (ki_ff <= 3'd4)) begin
               for (int l = 0; l < LANES; l++) begin
                  mul_a[l] = 34'(w_ff[wsel]);
                  mul_b[l] = axis_pt[l];
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < LANES; l++) begin
         prod_ff[l] <= mul_a[l] * mul_b[l];
      end
   end

   // ---------------- state machine ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_bus.ready = 1'b0;
      out_load      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid && (req_bus.op == OP_TICK)) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP:  state_in = ST_ADD;
         ST_ADD:   state_in = ST_DIV;
         ST_DIV: begin
            if ((div_len_ff == '0) || (cnt_ff == 4'(DIV_STEPS - 1))) begin
               state_in = ST_TPREP;
            end
         end
         ST_TPREP: state_in = ST_W0;
         ST_W0:    state_in = ST_W1;
         ST_W1:    state_in = ST_W2;
         ST_W2:    state_in = ST_W3;
         ST_W3:    state_in = ST_POS;
         ST_POS: begin
            if (ki_ff == 3'd5) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_busy) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // ---------------- time and sequencing registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         anim_time_ff <= '0;
      end else if ((state_ff == ST_DIV) && (div_len_ff == '0)) begin
         anim_time_ff <= num_ff[TIME_W-1:0];
      end else if ((state_ff == ST_DIV) && (cnt_ff == 4'(DIV_STEPS - 1))) begin
         anim_time_ff <= r2m;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            delta_ff <= req_bus.delta_time;
         end
         ST_ADD: begin
            num_ff     <= {1'b0, num_sum};
            div_len_ff <= loop_length_ff;
            rem_ff     <= '0;
            cnt_ff     <= '0;
         end
         ST_DIV: begin
            num_ff <= {num_ff[27:0], 2'b00};
            rem_ff <= r2m;
            cnt_ff <= cnt_ff + 4'd1;
         end
         ST_TPREP: begin
            t_ff    <= t_new;
            u_ff    <= 17'h10000 - t_new;
            pidx_ff <= base_tab[anim_time_ff[TIME_W-1:16]];
         end
         ST_W1: begin
            ut_ff <= prod_ff[2][32:0];
         end
         ST_W2: begin
            w_ff[0] <= prod_ff[0][48:16];
            w_ff[1] <= x3_u2t[48:16];
            w_ff[3] <= prod_ff[2][48:16];
         end
         ST_W3: begin
            w_ff[2] <= x3_ut2[48:16];
            ki_ff   <= '0;
            for (int l = 0; l < LANES; l++) begin
               acc_ff[l] <= '0;
            end
         end
         ST_POS: begin
            if (ki_ff < 3'd4) begin
               pidx_ff <= (pidx_ff == IDX_W'(NUM_POINTS - 1)) ? '0 : pidx_ff + IDX_W'(1);
            end
            if (ki_ff >= 3'd2) begin
               for (int l = 0; l < LANES; l++) begin
                  acc_ff[l] <= acc_ff[l] + ACC_W'(prod_ff[l]);
               end
            end
            ki_ff <= ki_ff + 3'd1;
         end
         default: ;
      endcase
   end

   // ---------------- output register ----------------
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         fl[l] = acc_ff[l][ACC_W-1:32];   // arithmetic drop of 32 bits = floor
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_x_ff <= sat_coord(fl[0]);
         rsp_y_ff <= sat_coord(fl[1]);
         rsp_z_ff <= sat_coord(fl[2]);
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.pos_x = rsp_x_ff;
   assign rsp_bus.pos_y = rsp_y_ff;
   assign rsp_bus.pos_z = rsp_z_ff;

   // ---------------- assertions ----------------
   a_wrap_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TPREP && div_len_ff != '0) |-> (anim_time_ff < div_len_ff))
      else $error("wrapped time not below loop length");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside final load");

   a_pidx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POS) |-> ({1'b0, pidx_ff} < (IDX_W+1)'(NUM_POINTS)))
      else $error("table pointer out of range");

endmodule

// ===== test/cbpf_path_checker.sv =====
// Channel monitor for the Bezier path follower: tracks config, predicts positions, compares.
module cbpf_path_checker import cbpf_pkg::*; #(
   parameter int NUM_POINTS = 100
) (
   input  logic        clock,
   input  logic        reset,
   cbpf_req_if         req_mon,
   cbpf_rsp_if         rsp_mon,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic        pready,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output int          failures,
   output int          pending
);

   localparam longint POS_HI = 131071;
   localparam longint POS_LO = -131072;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } position_type;

   logic signed [COORD_W-1:0] path_pts [NUM_POINTS][3];
   logic [TIME_W-1:0]         anim_time;
   logic [GAIN_W-1:0]         speed_gain;
   logic [TIME_W-1:0]         loop_length;
   position_type              expected_positions [$];
   int                        fail_cnt;

   // advance the time by one tick and blend the four points of its segment
   function automatic position_type next_position(input logic [DT_W-1:0] dt);
      logic [63:0]               tm;
      logic [63:0]               frac;
      logic [63:0]               rem;
      logic [63:0]               w [4];
      int                        base;
      int                        p;
      longint                    acc;
      logic signed [COORD_W-1:0] axis_out [3];
      position_type              r;
      tm = 64'(anim_time) + ((64'(dt) * 64'(speed_gain)) >> 8);
      if (loop_length != '0) begin
         tm = tm % 64'(loop_length);
      end
      anim_time = tm[TIME_W-1:0];
      base = (int'(anim_time[TIME_W-1:16]) * 3) % NUM_POINTS;
      frac = 64'(anim_time[15:0]);
      // whole nonzero time takes t = 1.0 at the end of the segment its whole part selects
      if (frac == 0 && anim_time != '0) begin
         frac = 64'd65536;
      end
      rem = 64'd65536 - frac;
      w[0] = (rem * rem * rem) >> 16;
      w[1] = (64'd3 * rem * rem * frac) >> 16;
      w[2] = (64'd3 * rem * frac * frac) >> 16;
      w[3] = (frac * frac * frac) >> 16;
      for (int a = 0; a < 3; a++) begin
         acc = 0;
         for (int k = 0; k < 4; k++) begin
            p = (base + k) % NUM_POINTS;
            acc += longint'(w[k]) * longint'(path_pts[p][a]);
         end
         acc = acc >>> 32;
         if (acc > POS_HI) begin
            axis_out[a] = POS_HI[COORD_W-1:0];
         end else if (acc < POS_LO) begin
            axis_out[a] = POS_LO[COORD_W-1:0];
         end else begin
            axis_out[a] = acc[COORD_W-1:0];
         end
      end
      r.x = axis_out[0];
      r.y = axis_out[1];
      r.z = axis_out[2];
      return r;
   endfunction

   always @(posedge clock) begin
      position_type want;
      if (reset) begin
         anim_time   = '0;
         speed_gain  = GAIN_RESET;
         loop_length = LOOP_RESET;
         fail_cnt    = 0;
         expected_positions.delete();
      end else begin
         // response first: a beat never belongs to a tick taken at the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_positions.size() == 0) begin
               $error("unexpected position beat: x=%0d y=%0d z=%0d",
                      rsp_mon.pos_x, rsp_mon.pos_y, rsp_mon.pos_z);
               fail_cnt++;
            end else begin
               want = expected_positions.pop_front();
               if (rsp_mon.pos_x !== want.x) begin
                  $error("pos_x: expected %0d, actual %0d", want.x, rsp_mon.pos_x);
                  fail_cnt++;
               end
               if (rsp_mon.pos_y !== want.y) begin
                  $error("pos_y: expected %0d, actual %0d", want.y, rsp_mon.pos_y);
                  fail_cnt++;
               end
               if (rsp_mon.pos_z !== want.z) begin
                  $error("pos_z: expected %0d, actual %0d", want.z, rsp_mon.pos_z);
                  fail_cnt++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.op == OP_TICK) begin
               expected_positions.push_back(next_position(req_mon.delta_time));
            end else if (int'(req_mon.point_index) < NUM_POINTS) begin
               path_pts[req_mon.point_index][0] = req_mon.point_x;
               path_pts[req_mon.point_index][1] = req_mon.point_y;
               path_pts[req_mon.point_index][2] = req_mon.point_z;
            end
         end
         if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_SPEED_GAIN) begin
               speed_gain = pwdata[GAIN_W-1:0];
            end else begin
               loop_length = pwdata[TIME_W-1:0];
            end
         end
      end
      pending  <= expected_positions.size();
      failures <= fail_cnt;
   end

endmodule

// ===== test/cubic_bezier_path_follower_core_test.sv =====
// Top of the path follower bench: clock, reset, stimulus, config phases and verdict.
module cubic_bezier_path_follower_core_test import cbpf_pkg::*;;

   localparam int NUM_POINTS      = 100;
   // tick latency, and the settle time derived from it before touching the registers
   localparam int TICK_LATENCY    = 29;
   localparam int SETTLE_CYCLES   = 2 * TICK_LATENCY;
   // longest legal quiet stretch is about a tick plus a stall plus a settle
   localparam int STALL_LIMIT     = 1000;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 55;
   localparam int RESET_CYCLES    = 12;
   localparam int GAP_MAX         = 12;

   localparam logic signed [COORD_W-1:0] COORD_HI = 18'sd131071;
   localparam logic signed [COORD_W-1:0] COORD_LO = -18'sd131072;
   localparam logic [DT_W-1:0]           DT_MAX   = '1;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;
   int          failures;
   int          pending;
   int          quiet_cycles;
   int          req_burst;

   cbpf_req_if req_bus ();
   cbpf_rsp_if rsp_bus ();

   cubic_bezier_path_follower_core #(.NUM_POINTS(NUM_POINTS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   cbpf_path_checker #(.NUM_POINTS(NUM_POINTS)) path_check (
      .clock    (clock),
      .reset    (reset),
      .req_mon  (req_bus),
      .rsp_mon  (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .pready   (pready),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .failures (failures),
      .pending  (pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Wait before the next beat: a random gap up to GAP_MAX, with occasional runs of
   // back-to-back beats so the datapath also sees no idling at all.
   function automatic int draw_gap(inout int burst);
      if (burst > 0) begin
         burst--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         burst = $urandom_range(10, 30);
         return 0;
      end
      return $urandom_range(0, GAP_MAX);
   endfunction

   // Mostly full-range values, with the rails thrown in now and then.
   function automatic logic signed [COORD_W-1:0] random_coord();
      case ($urandom_range(0, 9))
         0:       return COORD_HI;
         1:       return COORD_LO;
         default: return COORD_W'($urandom);
      endcase
   endfunction

   // Frame times: full range, short frames, frozen frames and the longest one.
   function automatic logic [DT_W-1:0] random_dt();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return DT_MAX;
         2, 3:    return DT_W'($urandom_range(0, 4095));
         default: return DT_W'($urandom);
      endcase
   endfunction

   // One request beat. valid is only lowered when a gap is drawn, so a
   // back-to-back beat keeps valid high across the accept edge.
   task automatic send_beat(input logic op, input logic [PIDX_W-1:0] idx,
                            input logic signed [COORD_W-1:0] px, py, pz,
                            input logic [DT_W-1:0] dt);
      int gap;
      gap = draw_gap(req_burst);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.op          <= op;
      req_bus.point_index <= idx;
      req_bus.point_x     <= px;
      req_bus.point_y     <= py;
      req_bus.point_z     <= pz;
      req_bus.delta_time  <= dt;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Fields a tick does not use carry noise, and the other way round.
   task automatic send_tick(input logic [DT_W-1:0] dt);
      send_beat(OP_TICK, PIDX_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
                COORD_W'($urandom), dt);
   endtask

   task automatic send_write(input logic [PIDX_W-1:0] idx,
                             input logic signed [COORD_W-1:0] px, py, pz);
      send_beat(OP_WRITE, idx, px, py, pz, DT_W'($urandom));
   endtask

   // Hold the request side until every position has come back, then let the
   // block settle so a trailing point write has surely landed.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write: setup, access until pready, then psel drops before the next transfer so that
   // back-to-back writes never touch psel twice in one step.
   task automatic csr_write(input logic reg_sel, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Watchdog: any accepted beat or register write counts as progress.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (psel && penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      wait (quiet_cycles >= STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // Receiver: stalls a random gap up to GAP_MAX before each position beat.
   initial begin
      int stall;
      int rsp_burst;
      rsp_burst = 0;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = draw_gap(rsp_burst);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   initial begin
      logic [GAIN_W-1:0] gain;
      logic [TIME_W-1:0] loop_len;
      req_burst           = 0;
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.op          <= OP_WRITE;
      req_bus.point_index <= '0;
      req_bus.point_x     <= '0;
      req_bus.point_y     <= '0;
      req_bus.point_z     <= '0;
      req_bus.delta_time  <= '0;
      psel                <= 1'b0;
      penable             <= 1'b0;
      pwrite              <= 1'b0;
      paddr               <= '0;
      pwdata              <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // unit gain so directed frame times map straight onto path time
      csr_write(REG_SPEED_GAIN, 32'd256);

      // the table is undefined after reset: fill every entry before any tick
      for (int i = 0; i < NUM_POINTS; i++) begin
         send_write(PIDX_W'(i), random_coord(), random_coord(), random_coord());
      end

      // --- directed ---
      send_tick('0);                 // time still zero: t stays 0, point 0 itself
      send_tick(DT_W'(65536));       // whole time 1.0: end of segment 1, t = 1.0
      send_tick('0);                 // frozen frame at nonzero time
      send_tick(DT_W'(32768));       // mid segment 1
      send_tick(DT_MAX);             // longest frame
      send_tick(DT_MAX);             // crosses the loop length, wraps
      // rails in the points that the last segment wraps onto
      send_write(PIDX_W'(NUM_POINTS - 1), COORD_HI, COORD_LO, COORD_HI);
      send_write(PIDX_W'(0), COORD_HI, COORD_HI, COORD_HI);
      send_write(PIDX_W'(1), COORD_LO, COORD_LO, COORD_LO);
      send_write(PIDX_W'(2), COORD_HI, COORD_LO, COORD_LO);
      // writes past the table are dropped
      send_write(PIDX_W'(NUM_POINTS), COORD_LO, COORD_LO, COORD_LO);
      send_write('1, COORD_LO, COORD_HI, COORD_LO);
      send_tick(DT_MAX);
      send_tick(DT_MAX);
      send_tick(DT_W'(65536));       // lands in segment 33: points 99, 0, 1, 2
      send_tick(DT_W'(1));
      send_tick(DT_W'(4095));
      drain_results();

      // --- random phases, each under its own register setting ---
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin gain = GAIN_RESET;   loop_len = LOOP_RESET;          end
            1: begin gain = '1;           loop_len = '1;                  end
            2: begin gain = '0;           loop_len = TIME_W'(1);          end
            3: begin gain = GAIN_W'(1);   loop_len = TIME_W'(65536);      end
            4: begin
               gain     = GAIN_W'($urandom);
               loop_len = TIME_W'($urandom_range(1, 1000000));
            end
            default: begin gain = '1;     loop_len = TIME_W'(1);          end
         endcase
         csr_write(REG_SPEED_GAIN, 32'(gain));
         csr_write(REG_LOOP_LENGTH, 32'(loop_len));
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ($urandom_range(0, 99) < 60) begin
               send_tick(random_dt());
            end else begin
               send_write(PIDX_W'($urandom_range(0, 127)), random_coord(), random_coord(),
                          random_coord());
            end
            // now and then hold off until the block has emptied
            if ($urandom_range(0, 39) == 0) begin
               drain_results();
            end
         end
         drain_results();
      end

      if (failures == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
